// ===== rtl/m3i_pkg.sv =====
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared widths and types for the 3x3 fixed-point matrix inverse.
// ----------------------------------------------------------------------------
package m3i_pkg;

   localparam int DW   = 32;              // element width
   localparam int FB   = 16;              // fraction bits
   localparam int IN_W = 32;              // port field width
   localparam int PW   = 2 * DW;          // product width
   localparam int AW   = PW + 1;          // adjugate element width
   localparam int DETW = AW + DW + 2;     // determinant width
   localparam int NW   = AW + 2 * FB;     // scaled numerator magnitude width
   localparam int RW   = DETW + 1;        // partial remainder width
   localparam int CW   = (NW > DETW + DW) ? NW : DETW + DW;

   typedef logic signed [DW-1:0]   elem_type;
   typedef elem_type [8:0]         mat_type;
   typedef logic signed [AW-1:0]   adj_type;
   typedef adj_type [8:0]          adjv_type;
   typedef logic signed [DETW-1:0] det_type;

endpackage

// ===== rtl/m3i_front.sv =====
// ----------------------------------------------------------------------------
// m3i_front
// Four-stage pipeline forming the exact adjugate and determinant.
// ----------------------------------------------------------------------------
module m3i_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  m3i_pkg::mat_type in_a,
   output logic             out_valid,
   output m3i_pkg::mat_type out_a,
   output m3i_pkg::adjv_type out_adj,
   output m3i_pkg::det_type out_det
);

   localparam int MI [9][4] = '{
      '{4, 8, 7, 5}, '{1, 8, 7, 2}, '{1, 5, 4, 2},
      '{3, 8, 6, 5}, '{0, 8, 6, 2}, '{0, 5, 3, 2},
      '{3, 7, 6, 4}, '{0, 7, 6, 1}, '{0, 4, 3, 1}
   };
   localparam bit NEG [9] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

   logic [3:0]                   valid_ff;
   m3i_pkg::mat_type             a1_ff, a2_ff, a3_ff, a4_ff;
   logic signed [m3i_pkg::PW-1:0] pa_ff [9];
   logic signed [m3i_pkg::PW-1:0] pb_ff [9];
   m3i_pkg::adjv_type            adj2_ff, adj3_ff, adj4_ff;
   logic signed [m3i_pkg::PW:0]  ml_ff [3];
   logic signed [m3i_pkg::PW:0]  mh_ff [3];
   m3i_pkg::det_type             det4_ff;

   m3i_pkg::adjv_type            adj2_in;
   logic signed [m3i_pkg::PW:0]  ml_in [3];
   logic signed [m3i_pkg::PW:0]  mh_in [3];
   m3i_pkg::det_type             det4_in;

   always_comb begin
      logic signed [m3i_pkg::AW-1:0] d;
      logic signed [m3i_pkg::DW:0]   lo;
      logic signed [m3i_pkg::DW:0]   hi;
      for (int k = 0; k < 9; k++) begin
         d = m3i_pkg::AW'(pa_ff[k]) - m3i_pkg::AW'(pb_ff[k]);
         adj2_in[k] = NEG[k] ? -d : d;
      end
      for (int j = 0; j < 3; j++) begin
         lo = $signed({1'b0, adj2_ff[3*j][m3i_pkg::DW-1:0]});
         hi = $signed(adj2_ff[3*j][m3i_pkg::AW-1:m3i_pkg::DW]);
         ml_in[j] = (m3i_pkg::PW+1)'(a2_ff[j]) * (m3i_pkg::PW+1)'(lo);
         mh_in[j] = (m3i_pkg::PW+1)'(a2_ff[j]) * (m3i_pkg::PW+1)'(hi);
      end
      det4_in = '0;
      for (int j = 0; j < 3; j++) begin
         det4_in = det4_in + (m3i_pkg::DETW'(mh_ff[j]) <<< m3i_pkg::DW)
                   + m3i_pkg::DETW'(ml_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 9; k++) begin
            pa_ff[k] <= m3i_pkg::PW'(in_a[MI[k][0]]) * m3i_pkg::PW'(in_a[MI[k][1]]);
            pb_ff[k] <= m3i_pkg::PW'(in_a[MI[k][2]]) * m3i_pkg::PW'(in_a[MI[k][3]]);
         end
         a1_ff   <= in_a;
         a2_ff   <= a1_ff;
         adj2_ff <= adj2_in;
         a3_ff   <= a2_ff;
         adj3_ff <= adj2_ff;
         ml_ff   <= ml_in;
         mh_ff   <= mh_in;
         a4_ff   <= a3_ff;
         adj4_ff <= adj3_ff;
         det4_ff <= det4_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_a     = a4_ff;
   assign out_adj   = adj4_ff;
   assign out_det   = det4_ff;

endmodule

// ===== rtl/m3i_div_lane.sv =====
// ----------------------------------------------------------------------------
// m3i_div_lane
// Pipelined restoring divider, one quotient bit per stage, with an
// up-front check for quotients that do not fit the element width.
// ----------------------------------------------------------------------------
module m3i_div_lane (
   input  logic                        clock,
   input  logic                        en,
   input  logic [m3i_pkg::NW-1:0]      num,
   input  logic [m3i_pkg::DETW-1:0]    den,
   input  logic                        neg,
   output logic [m3i_pkg::DW-1:0]      quo,
   output logic                        big,
   output logic                        quo_neg
);

   localparam int DW = m3i_pkg::DW;
   localparam int RW = m3i_pkg::RW;

   logic [RW-1:0]                rem_ff [DW+1];
   logic [DW-1:0]                q_ff   [DW+1];
   logic [DW-1:0]                lo_ff  [DW+1];
   logic [m3i_pkg::DETW-1:0]     den_ff [DW+1];
   logic                         big_ff [DW+1];
   logic                         neg_ff [DW+1];

   logic [RW-1:0]                rem_in [DW+1];
   logic [DW-1:0]                q_in   [DW+1];

   always_comb begin
      logic [RW-1:0] t;
      logic          geq;
      rem_in[0] = RW'(num >> DW);
      q_in[0]   = '0;
      for (int s = 1; s <= DW; s++) begin
         t   = {rem_ff[s-1][RW-2:0], lo_ff[s-1][DW-1]};
         geq = t >= RW'(den_ff[s-1]);
         rem_in[s] = geq ? t - RW'(den_ff[s-1]) : t;
         q_in[s]   = {q_ff[s-1][DW-2:0], geq};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem_in[0];
         q_ff[0]   <= q_in[0];
         lo_ff[0]  <= num[DW-1:0];
         den_ff[0] <= den;
         big_ff[0] <= m3i_pkg::CW'(num) >= (m3i_pkg::CW'(den) << DW);
         neg_ff[0] <= neg;
         for (int s = 1; s <= DW; s++) begin
            rem_ff[s] <= rem_in[s];
            q_ff[s]   <= q_in[s];
            lo_ff[s]  <= lo_ff[s-1] << 1;
            den_ff[s] <= den_ff[s-1];
            big_ff[s] <= big_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
         end
      end
   end

   assign quo     = q_ff[DW];
   assign big     = big_ff[DW];
   assign quo_neg = neg_ff[DW];

endmodule

// ===== rtl/matrix3_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix3_inverse
// 3x3 signed fixed-point matrix inverse by the adjugate, each element
// divided directly by the determinant, with saturation and singular pass.
//
//   channel   direction   handshake           payload
//   req       in          req_valid/stall     req_a00 .. req_a22
//   rsp       out         rsp_valid/stall     rsp_r00 .. rsp_r22, singular, overflow
//
// one word enters per cycle unless a stalled response holds it; a word passes the front,
// the sign register, the bit-per-stage divider pipeline and the output register
// reset clears only the valid bits
// a stalled response freezes the whole pipeline; nothing is dropped
// ----------------------------------------------------------------------------
module matrix3_inverse (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_a00, req_a01, req_a02,
   input  logic [31:0] req_a10, req_a11, req_a12,
   input  logic [31:0] req_a20, req_a21, req_a22,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_r00, rsp_r01, rsp_r02,
   output logic [31:0] rsp_r10, rsp_r11, rsp_r12,
   output logic [31:0] rsp_r20, rsp_r21, rsp_r22,
   output logic        rsp_singular,
   output logic        rsp_overflow
);

   localparam int DW = m3i_pkg::DW;
   localparam int AW = m3i_pkg::AW;

   logic              en;
   m3i_pkg::mat_type  in_a;
   logic              f_valid;
   m3i_pkg::mat_type  f_a;
   m3i_pkg::adjv_type f_adj;
   m3i_pkg::det_type  f_det;

   logic                      p_valid_ff, p_zero_ff;
   m3i_pkg::mat_type          p_a_ff;
   logic [m3i_pkg::NW-1:0]    p_num_ff [9];
   logic [m3i_pkg::DETW-1:0]  p_den_ff;
   logic [8:0]                p_neg_ff;

   logic [DW:0]               sv_ff;
   logic                      sz_ff [DW+1];
   m3i_pkg::mat_type          sa_ff [DW+1];

   logic [DW-1:0]             d_quo [9];
   logic [8:0]                d_big, d_neg;

   logic                      rsp_valid_ff, rsp_singular_ff, rsp_overflow_ff;
   m3i_pkg::mat_type          rsp_r_ff;
   m3i_pkg::mat_type          rsp_r_in;
   logic                      rsp_overflow_in;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   assign in_a = '{req_a22[DW-1:0], req_a21[DW-1:0], req_a20[DW-1:0],
                   req_a12[DW-1:0], req_a11[DW-1:0], req_a10[DW-1:0],
                   req_a02[DW-1:0], req_a01[DW-1:0], req_a00[DW-1:0]};

   m3i_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_a      (in_a),
      .out_valid (f_valid),
      .out_a     (f_a),
      .out_adj   (f_adj),
      .out_det   (f_det)
   );

   // magnitudes and signs for the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= f_valid;
      end
   end

   always_ff @(posedge clock) begin
      logic [AW-1:0] mag;
      if (en) begin
         p_a_ff    <= f_a;
         p_zero_ff <= f_det == '0;
         p_den_ff  <= f_det[m3i_pkg::DETW-1] ? m3i_pkg::DETW'(-f_det)
                                             : m3i_pkg::DETW'(f_det);
         for (int k = 0; k < 9; k++) begin
            mag = f_adj[k][AW-1] ? AW'(-f_adj[k]) : AW'(f_adj[k]);
            p_num_ff[k] <= m3i_pkg::NW'(mag) << (2 * m3i_pkg::FB);
            p_neg_ff[k] <= f_adj[k][AW-1] ^ f_det[m3i_pkg::DETW-1];
         end
      end
   end

   for (genvar k = 0; k < 9; k++) begin : g_lane
      m3i_div_lane u_div (
         .clock   (clock),
         .en      (en),
         .num     (p_num_ff[k]),
         .den     (p_den_ff),
         .neg     (p_neg_ff[k]),
         .quo     (d_quo[k]),
         .big     (d_big[k]),
         .quo_neg (d_neg[k])
      );
   end

   // side line alongside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= '0;
      end else if (en) begin
         sv_ff <= {sv_ff[DW-1:0], p_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sz_ff[0] <= p_zero_ff;
         sa_ff[0] <= p_a_ff;
         for (int s = 1; s <= DW; s++) begin
            sz_ff[s] <= sz_ff[s-1];
            sa_ff[s] <= sa_ff[s-1];
         end
      end
   end

   // saturation and singular select
   always_comb begin
      logic ovf;
      rsp_overflow_in = 1'b0;
      for (int k = 0; k < 9; k++) begin
         if (d_neg[k]) begin
            ovf = d_big[k] || (d_quo[k][DW-1] && (d_quo[k][DW-2:0] != '0));
            rsp_r_in[k] = ovf ? $signed({1'b1, {(DW-1){1'b0}}}) : $signed(-d_quo[k]);
         end else begin
            ovf = d_big[k] || d_quo[k][DW-1];
            rsp_r_in[k] = ovf ? $signed({1'b0, {(DW-1){1'b1}}}) : $signed(d_quo[k]);
         end
         rsp_overflow_in = rsp_overflow_in | ovf;
      end
      if (sz_ff[DW]) begin
         rsp_r_in        = sa_ff[DW];
         rsp_overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sv_ff[DW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_r_ff        <= rsp_r_in;
         rsp_singular_ff <= sz_ff[DW];
         rsp_overflow_ff <= rsp_overflow_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_singular = rsp_singular_ff;
   assign rsp_overflow = rsp_overflow_ff;
   assign rsp_r00 = m3i_pkg::IN_W'(rsp_r_ff[0]);
   assign rsp_r01 = m3i_pkg::IN_W'(rsp_r_ff[1]);
   assign rsp_r02 = m3i_pkg::IN_W'(rsp_r_ff[2]);
   assign rsp_r10 = m3i_pkg::IN_W'(rsp_r_ff[3]);
   assign rsp_r11 = m3i_pkg::IN_W'(rsp_r_ff[4]);
   assign rsp_r12 = m3i_pkg::IN_W'(rsp_r_ff[5]);
   assign rsp_r20 = m3i_pkg::IN_W'(rsp_r_ff[6]);
   assign rsp_r21 = m3i_pkg::IN_W'(rsp_r_ff[7]);
   assign rsp_r22 = m3i_pkg::IN_W'(rsp_r_ff[8]);

endmodule
